>>> rtl/fixed_point_alu_unit_defines.svh
// Assertion macros used by fixed_point_alu_unit.
`ifndef FIXED_POINT_ALU_UNIT_DEFINES_SVH
`define FIXED_POINT_ALU_UNIT_DEFINES_SVH

`define FPA_ASSERT_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("fixed point alu check failed");

`define FPA_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("fixed point alu check failed");

`endif

>>> rtl/fpa_pkg.sv
`default_nettype none
package fpa_pkg;

    typedef enum logic [3:0] {
        OP_ADD      = 4'd0,
        OP_SUB      = 4'd1,
        OP_MUL      = 4'd2,
        OP_DIV      = 4'd3,
        OP_MIN      = 4'd4,
        OP_MAX      = 4'd5,
        OP_GT       = 4'd6,
        OP_LT       = 4'd7,
        OP_GE       = 4'd8,
        OP_LE       = 4'd9,
        OP_EQ       = 4'd10,
        OP_NE       = 4'd11,
        OP_INC      = 4'd12,
        OP_DEC      = 4'd13,
        OP_FROM_INT = 4'd14,
        OP_TO_INT   = 4'd15
    } t_op;

    typedef struct packed {
        t_op                op;
        logic signed [31:0] a;
        logic signed [31:0] b;
        logic        [31:0] den;
        logic signed [63:0] prod;
    } t_tag;

    localparam logic signed [31:0] SAT_MAX = 32'sh7FFF_FFFF;
    localparam logic signed [31:0] SAT_MIN = 32'sh8000_0000;

endpackage
`default_nettype wire

>>> rtl/fpa_front.sv
`default_nettype none
module fpa_front #(
    parameter int FRAC_BITS = 8,
    parameter int NUM_W     = 33 + FRAC_BITS
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_en,
    input  wire                     i_valid,
    input  wire  [3:0]              i_opcode,
    input  wire  signed [31:0]      i_operand_a,
    input  wire  signed [31:0]      i_operand_b,
    output logic                    o_valid,
    output fpa_pkg::t_tag           o_tag,
    output logic [NUM_W-1:0]        o_num
);

    logic                r_valid;
    fpa_pkg::t_tag       r_tag;
    fpa_pkg::t_tag       n_tag;
    logic [NUM_W-1:0]    r_num;
    logic [NUM_W-1:0]    n_num;
    logic [31:0]         mag_a;
    logic [31:0]         mag_b;

    always_comb begin
        mag_a      = i_operand_a[31] ? (~i_operand_a + 32'd1) : i_operand_a;
        mag_b      = i_operand_b[31] ? (~i_operand_b + 32'd1) : i_operand_b;
        n_tag.op   = fpa_pkg::t_op'(i_opcode);
        n_tag.a    = i_operand_a;
        n_tag.b    = i_operand_b;
        n_tag.den  = mag_b;
        n_tag.prod = 64'(i_operand_a) * 64'(i_operand_b);
        n_num      = NUM_W'({mag_a, {FRAC_BITS{1'b0}}}) + NUM_W'(mag_b[31:1]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tag <= n_tag;
            r_num <= n_num;
        end
    end

    assign o_valid = r_valid;
    assign o_tag   = r_tag;
    assign o_num   = r_num;

endmodule
`default_nettype wire

>>> rtl/fpa_div_cell.sv
`default_nettype none
module fpa_div_cell #(
    parameter int NUM_W = 41
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_en,
    input  wire                     i_valid,
    input  wire fpa_pkg::t_tag      i_tag,
    input  wire  [31:0]             i_rem,
    input  wire  [NUM_W-1:0]        i_nq,
    output logic                    o_valid,
    output fpa_pkg::t_tag           o_tag,
    output logic [31:0]             o_rem,
    output logic [NUM_W-1:0]        o_nq
);

    // One restoring division step: shift in the next numerator bit and
    // shift the quotient bit in at the bottom of the same register.
    logic                r_valid;
    fpa_pkg::t_tag       r_tag;
    logic [31:0]         r_rem;
    logic [31:0]         n_rem;
    logic [NUM_W-1:0]    r_nq;
    logic [NUM_W-1:0]    n_nq;
    logic [32:0]         rs;
    logic [32:0]         diff;
    logic                ge;

    always_comb begin
        rs    = {i_rem, i_nq[NUM_W-1]};
        diff  = rs - {1'b0, i_tag.den};
        ge    = rs >= {1'b0, i_tag.den};
        n_rem = ge ? diff[31:0] : rs[31:0];
        n_nq  = {i_nq[NUM_W-2:0], ge};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_tag <= i_tag;
            r_rem <= n_rem;
            r_nq  <= n_nq;
        end
    end

    assign o_valid = r_valid;
    assign o_tag   = r_tag;
    assign o_rem   = r_rem;
    assign o_nq    = r_nq;

endmodule
`default_nettype wire

>>> rtl/fpa_back.sv
`default_nettype none
module fpa_back #(
    parameter int FRAC_BITS = 8,
    parameter int NUM_W     = 33 + FRAC_BITS
) (
    input  wire                     i_clk,
    input  wire                     i_rst_n,
    input  wire                     i_en,
    input  wire                     i_valid,
    input  wire fpa_pkg::t_tag      i_tag,
    input  wire  [NUM_W-1:0]        i_quot,
    output logic                    o_valid,
    output logic signed [31:0]      o_result_value,
    output logic                    o_compare_true,
    output logic                    o_divide_by_zero,
    output logic                    o_overflowed
);

    localparam logic [63:0] HALF = 64'(1) << (FRAC_BITS - 1);

    logic               r_valid;
    logic signed [31:0] r_res;
    logic signed [31:0] n_res;
    logic               r_cmp;
    logic               n_cmp;
    logic               r_dz;
    logic               n_dz;
    logic               r_ovf;
    logic               n_ovf;
    logic signed [32:0] sum;
    logic signed [32:0] addend;
    logic [63:0]        pm;
    logic [63:0]        rm;
    logic               pneg;
    logic               qneg;
    logic [63:0]        fi;
    logic [31:0]        mag_a;
    logic [31:0]        ti;

    always_comb begin
        n_res  = '0;
        n_cmp  = 1'b0;
        n_dz   = 1'b0;
        n_ovf  = 1'b0;
        case (i_tag.op)
            fpa_pkg::OP_SUB: addend = -33'(i_tag.b);
            fpa_pkg::OP_INC: addend = 33'sd1;
            fpa_pkg::OP_DEC: addend = -33'sd1;
            default:         addend = 33'(i_tag.b);
        endcase
        sum   = 33'(i_tag.a) + addend;
        pneg  = i_tag.prod[63];
        pm    = pneg ? (~i_tag.prod + 64'd1) : i_tag.prod;
        rm    = (pm + HALF) >> FRAC_BITS;
        qneg  = i_tag.a[31] ^ i_tag.b[31];
        fi    = {{32{i_tag.a[31]}}, i_tag.a} << FRAC_BITS;
        mag_a = i_tag.a[31] ? (~i_tag.a + 32'd1) : i_tag.a;
        ti    = mag_a >> FRAC_BITS;
        case (i_tag.op)
            fpa_pkg::OP_ADD, fpa_pkg::OP_SUB, fpa_pkg::OP_INC, fpa_pkg::OP_DEC: begin
                n_ovf = sum[32] != sum[31];
                n_res = n_ovf ? (sum[32] ? fpa_pkg::SAT_MIN : fpa_pkg::SAT_MAX) : sum[31:0];
            end
            fpa_pkg::OP_MUL: begin
                n_ovf = pneg ? (rm > 64'h8000_0000) : (rm > 64'h7FFF_FFFF);
                n_res = n_ovf ? (pneg ? fpa_pkg::SAT_MIN : fpa_pkg::SAT_MAX)
                              : (pneg ? -rm[31:0] : rm[31:0]);
            end
            fpa_pkg::OP_DIV: begin
                if (i_tag.b == '0) begin
                    n_dz  = 1'b1;
                    n_res = i_tag.a;
                end else begin
                    n_ovf = qneg ? (i_quot > NUM_W'(32'h8000_0000))
                                 : (i_quot > NUM_W'(32'h7FFF_FFFF));
                    n_res = n_ovf ? (qneg ? fpa_pkg::SAT_MIN : fpa_pkg::SAT_MAX)
                                  : (qneg ? -i_quot[31:0] : i_quot[31:0]);
                end
            end
            fpa_pkg::OP_MIN: n_res = (i_tag.b < i_tag.a) ? i_tag.b : i_tag.a;
            fpa_pkg::OP_MAX: n_res = (i_tag.b > i_tag.a) ? i_tag.b : i_tag.a;
            fpa_pkg::OP_GT:  n_cmp = i_tag.a >  i_tag.b;
            fpa_pkg::OP_LT:  n_cmp = i_tag.a <  i_tag.b;
            fpa_pkg::OP_GE:  n_cmp = i_tag.a >= i_tag.b;
            fpa_pkg::OP_LE:  n_cmp = i_tag.a <= i_tag.b;
            fpa_pkg::OP_EQ:  n_cmp = i_tag.a == i_tag.b;
            fpa_pkg::OP_NE:  n_cmp = i_tag.a != i_tag.b;
            fpa_pkg::OP_FROM_INT: begin
                n_ovf = (fi[63:31] != '0) && (fi[63:31] != '1);
                n_res = n_ovf ? (i_tag.a[31] ? fpa_pkg::SAT_MIN : fpa_pkg::SAT_MAX)
                              : fi[31:0];
            end
            fpa_pkg::OP_TO_INT: n_res = i_tag.a[31] ? -ti : ti;
            default: n_res = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_res <= n_res;
            r_cmp <= n_cmp;
            r_dz  <= n_dz;
            r_ovf <= n_ovf;
        end
    end

    assign o_valid          = r_valid;
    assign o_result_value   = r_res;
    assign o_compare_true   = r_cmp;
    assign o_divide_by_zero = r_dz;
    assign o_overflowed     = r_ovf;

endmodule
`default_nettype wire

>>> rtl/fixed_point_alu_unit.sv
// Channel   Direction  Handshake          Payload
// input     in         i_valid / o_stall  i_opcode, i_operand_a, i_operand_b
// result    out        o_valid / i_stall  o_result_value, o_compare_true,
//                                         o_divide_by_zero, o_overflowed
// One transfer is accepted per cycle while o_stall is low.
// The pipeline runs through a front stage, a row of divider cells (one quotient bit per cell) and a back stage.
// Reset is synchronous and clears only the valid bits of all stages.
// A stalled output freezes only full stages; empty stages keep filling.
`default_nettype none
`include "fixed_point_alu_unit_defines.svh"
module fixed_point_alu_unit #(
    parameter int FRAC_BITS = 8
) (
    input  wire                 i_clk,
    input  wire                 i_rst_n,
    input  wire                 i_valid,
    output logic                o_stall,
    input  wire  [3:0]          i_opcode,
    input  wire  signed [31:0]  i_operand_a,
    input  wire  signed [31:0]  i_operand_b,
    output logic                o_valid,
    input  wire                 i_stall,
    output logic signed [31:0]  o_result_value,
    output logic                o_compare_true,
    output logic                o_divide_by_zero,
    output logic                o_overflowed
);

    localparam int NUM_W  = 33 + FRAC_BITS;
    localparam int STAGES = NUM_W + 2;

    logic [STAGES-1:0] v;
    logic [STAGES-1:0] en;
    fpa_pkg::t_tag     tags [0:NUM_W];
    logic [31:0]       rems [0:NUM_W];
    logic [NUM_W-1:0]  nqs  [0:NUM_W];

    assign en[STAGES-1] = !v[STAGES-1] || !i_stall;

    genvar k;
    generate
        for (k = 0; k < STAGES - 1; k++) begin : g_en
            assign en[k] = !v[k] || en[k+1];
        end
    endgenerate

    assign o_stall = !en[0];
    assign rems[0] = '0;

    fpa_front #(
        .FRAC_BITS (FRAC_BITS),
        .NUM_W     (NUM_W)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_en        (en[0]),
        .i_valid     (i_valid),
        .i_opcode    (i_opcode),
        .i_operand_a (i_operand_a),
        .i_operand_b (i_operand_b),
        .o_valid     (v[0]),
        .o_tag       (tags[0]),
        .o_num       (nqs[0])
    );

    generate
        for (k = 1; k <= NUM_W; k++) begin : g_cell
            fpa_div_cell #(
                .NUM_W (NUM_W)
            ) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_en    (en[k]),
                .i_valid (v[k-1]),
                .i_tag   (tags[k-1]),
                .i_rem   (rems[k-1]),
                .i_nq    (nqs[k-1]),
                .o_valid (v[k]),
                .o_tag   (tags[k]),
                .o_rem   (rems[k]),
                .o_nq    (nqs[k])
            );
        end
    endgenerate

    fpa_back #(
        .FRAC_BITS (FRAC_BITS),
        .NUM_W     (NUM_W)
    ) u_back (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_en             (en[STAGES-1]),
        .i_valid          (v[NUM_W]),
        .i_tag            (tags[NUM_W]),
        .i_quot           (nqs[NUM_W]),
        .o_valid          (v[STAGES-1]),
        .o_result_value   (o_result_value),
        .o_compare_true   (o_compare_true),
        .o_divide_by_zero (o_divide_by_zero),
        .o_overflowed     (o_overflowed)
    );

    assign o_valid = v[STAGES-1];

    `FPA_ASSERT_IMPLY(a_dz_no_ovf, o_valid && o_divide_by_zero, !o_overflowed)
    `FPA_ASSERT_IMPLY(a_cmp_zero, o_valid && o_compare_true, o_result_value == '0)
    `FPA_ASSERT_IMPLY(a_stall_full, o_stall, o_valid && i_stall && (&v))
    `FPA_ASSERT_NEXT(a_out_held, o_valid && i_stall, o_valid)

endmodule
`default_nettype wire
